// ===== design/ucd_pkg.sv =====
// ----------------------------------------------------------------------------
// ucd_pkg
// Shared constants, types and helpers for the URL component decoder.
// ----------------------------------------------------------------------------
package ucd_pkg;

	localparam logic [7:0] CH_QUESTION = 8'h3F;
	localparam logic [7:0] CH_HASH     = 8'h23;
	localparam logic [7:0] CH_PERCENT  = 8'h25;
	localparam logic [7:0] CH_EQUALS   = 8'h3D;
	localparam logic [7:0] CH_AMP      = 8'h26;

	localparam logic [1:0] SEC_PATH  = 2'd0;
	localparam logic [1:0] SEC_QUERY = 2'd1;
	localparam logic [1:0] SEC_FRAG  = 2'd2;

	localparam logic [1:0] EV_BYTE = 2'd0;
	localparam logic [1:0] EV_KEY  = 2'd1;
	localparam logic [1:0] EV_PAIR = 2'd2;
	localparam logic [1:0] EV_END  = 2'd3;

	localparam logic [1:0] ESC_IDLE = 2'd0;
	localparam logic [1:0] ESC_HIGH = 2'd1;
	localparam logic [1:0] ESC_LOW  = 2'd2;

	typedef struct packed {
		logic [1:0] sec;
		logic [1:0] esc;
		logic [3:0] nib;
	} ucd_state_t;

	typedef struct packed {
		logic       main_v;
		logic [1:0] main_ev;
		logic [1:0] main_sec;
		logic [7:0] main_byte;
		logic       pair_v;
		logic       end_v;
		logic [1:0] end_sec;
	} ucd_group_t;

	function automatic logic [3:0] hex_value(input logic [7:0] c);
		logic [3:0] v;
		v = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			v = c[3:0];
		end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
			v = c[3:0] + 4'd9;
		end
		return v;
	endfunction

endpackage

// ===== design/ucd_decode.sv =====
// ----------------------------------------------------------------------------
// ucd_decode
// Per-byte decode: section tracking, percent escapes and query marks.
// ----------------------------------------------------------------------------
module ucd_decode (
	input  logic [7:0]         in_byte,
	input  logic               is_final,
	input  ucd_pkg::ucd_state_t st,
	output ucd_pkg::ucd_state_t st_d,
	output ucd_pkg::ucd_group_t grp
);
	import ucd_pkg::*;

	logic [1:0] sec;
	logic [3:0] hv;

	assign hv = hex_value(in_byte);

	always_comb begin
		st_d = st;
		grp  = '0;
		sec  = (st.sec > SEC_FRAG) ? SEC_FRAG : st.sec;

		if (st.esc == ESC_HIGH) begin
			st_d.nib = hv;
			st_d.esc = ESC_LOW;
		end else if (st.esc != ESC_IDLE) begin
			grp.main_v    = 1'b1;
			grp.main_ev   = EV_BYTE;
			grp.main_sec  = sec;
			grp.main_byte = {st.nib, hv};
			st_d.esc      = ESC_IDLE;
			st_d.nib      = 4'd0;
		end else if (in_byte == CH_PERCENT) begin
			st_d.esc = ESC_HIGH;
		end else if (sec == SEC_PATH && in_byte == CH_QUESTION) begin
			sec = SEC_QUERY;
		end else if (sec == SEC_PATH && in_byte == CH_HASH) begin
			sec = SEC_FRAG;
		end else if (sec == SEC_QUERY && in_byte == CH_HASH) begin
			grp.main_v   = 1'b1;
			grp.main_ev  = EV_PAIR;
			grp.main_sec = SEC_QUERY;
			sec          = SEC_FRAG;
		end else if (sec == SEC_QUERY && in_byte == CH_EQUALS) begin
			grp.main_v   = 1'b1;
			grp.main_ev  = EV_KEY;
			grp.main_sec = SEC_QUERY;
		end else if (sec == SEC_QUERY && in_byte == CH_AMP) begin
			grp.main_v   = 1'b1;
			grp.main_ev  = EV_PAIR;
			grp.main_sec = SEC_QUERY;
		end else begin
			grp.main_v    = 1'b1;
			grp.main_ev   = EV_BYTE;
			grp.main_sec  = sec;
			grp.main_byte = in_byte;
		end

		st_d.sec = sec;

		if (is_final) begin
			grp.pair_v  = (sec == SEC_QUERY);
			grp.end_v   = 1'b1;
			grp.end_sec = sec;
			st_d        = '0;
		end
	end

endmodule

// ===== design/url_component_decoder.sv =====
// ----------------------------------------------------------------------------
// url_component_decoder
// Latency: a word's first result is offered the cycle after it is accepted.
// Throughput: one input word per cycle while each word gives at most one
// result and out_stall is low; more results per word hold the input until
// the single result register, draining one per unstalled cycle, has one left.
// Reset: asynchronous, returns to the path section with no escape pending.
// ----------------------------------------------------------------------------
module url_component_decoder (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	input  logic       is_final,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] event_res,
	output logic [1:0] section,
	output logic [7:0] out_byte,
	output logic       run_last
);
	import ucd_pkg::*;

	ucd_state_t st_q;
	ucd_state_t st_d;
	ucd_group_t grp_d;
	ucd_group_t grp_q;
	logic [1:0] pend_cnt;
	logic       in_acc;
	logic       out_acc;

	ucd_decode u_decode (
		.in_byte  (in_byte),
		.is_final (is_final),
		.st       (st_q),
		.st_d     (st_d),
		.grp      (grp_d)
	);

	assign pend_cnt = {1'b0, grp_q.main_v} + {1'b0, grp_q.pair_v} + {1'b0, grp_q.end_v};
	assign out_valid = (pend_cnt != 2'd0);
	assign out_acc   = out_valid && !out_stall;
	assign in_stall  = out_valid && !(pend_cnt == 2'd1 && !out_stall);
	assign in_acc    = in_valid && !in_stall;

	always_comb begin
		if (grp_q.main_v) begin
			event_res = grp_q.main_ev;
			section   = grp_q.main_sec;
			out_byte  = grp_q.main_byte;
			run_last  = 1'b0;
		end else if (grp_q.pair_v) begin
			event_res = EV_PAIR;
			section   = SEC_QUERY;
			out_byte  = 8'd0;
			run_last  = 1'b0;
		end else begin
			event_res = EV_END;
			section   = grp_q.end_sec;
			out_byte  = 8'd0;
			run_last  = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= '0;
			grp_q <= '0;
		end else if (in_acc) begin
			st_q  <= st_d;
			grp_q <= grp_d;
		end else if (out_acc) begin
			if (grp_q.main_v) begin
				grp_q.main_v <= 1'b0;
			end else if (grp_q.pair_v) begin
				grp_q.pair_v <= 1'b0;
			end else begin
				grp_q.end_v <= 1'b0;
			end
		end
	end

endmodule

// ===== dv/tb_url_component_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_url_component_decoder
// Feeds whole URLs into the decoder byte by byte: directed strings for the
// section marks, the query marks and the percent escapes (whole, bad hex and
// cut short), then random URLs. A predictor in the bench builds the expected
// decoded words, and every word taken from the output is checked in order.
// Both sides idle and stall at random, with stretches of full rate.
// ----------------------------------------------------------------------------
module tb_url_component_decoder;
	import ucd_pkg::*;

	localparam int CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic [1:0] ev;
		logic [1:0] sec;
		logic [7:0] data;
		logic       last;
	} url_event_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] in_byte = 8'h00;
	logic       is_final = 1'b0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [1:0] event_res;
	logic [1:0] section;
	logic [7:0] out_byte;
	logic       run_last;

	url_event_t pending_events[$];
	logic [1:0] model_section = SEC_PATH;
	logic [1:0] model_escape = ESC_IDLE;
	logic [3:0] model_nibble = 4'd0;

	bit gap_on = 1'b1;
	bit stall_on = 1'b1;
	int stall_left = 0;
	int stall_roll;
	int items_sent = 0;
	int errors = 0;
	int cycle_count = 0;

	url_component_decoder i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_byte   (in_byte),
		.is_final  (is_final),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.event_res (event_res),
		.section   (section),
		.out_byte  (out_byte),
		.run_last  (run_last)
	);

	always #2 clk = ~clk;

	function automatic logic [3:0] nibble_of(input logic [7:0] c);
		logic [7:0] v;
		v = 8'd0;
		if (c >= "0" && c <= "9") begin
			v = c - "0";
		end else if (c >= "a" && c <= "f") begin
			v = c - "a" + 8'd10;
		end else if (c >= "A" && c <= "F") begin
			v = c - "A" + 8'd10;
		end
		return v[3:0];
	endfunction

	function automatic void queue_event(input logic [1:0] ev, input logic [1:0] sec,
			input logic [7:0] data, input logic last);
		url_event_t e;
		e.ev = ev;
		e.sec = sec;
		e.data = data;
		e.last = last;
		pending_events = {pending_events, e};
	endfunction

	function automatic void predict_events(input logic [7:0] b, input logic fin);
		logic [1:0] s;
		s = model_section;
		if (model_escape == ESC_HIGH) begin
			model_nibble = nibble_of(b);
			model_escape = ESC_LOW;
		end else if (model_escape != ESC_IDLE) begin
			queue_event(EV_BYTE, s, {model_nibble, nibble_of(b)}, 1'b0);
			model_escape = ESC_IDLE;
			model_nibble = 4'd0;
		end else if (b == CH_PERCENT) begin
			model_escape = ESC_HIGH;
		end else if (s == SEC_PATH && b == CH_QUESTION) begin
			s = SEC_QUERY;
		end else if (s == SEC_PATH && b == CH_HASH) begin
			s = SEC_FRAG;
		end else if (s == SEC_QUERY && b == CH_HASH) begin
			queue_event(EV_PAIR, SEC_QUERY, 8'h00, 1'b0);
			s = SEC_FRAG;
		end else if (s == SEC_QUERY && b == CH_EQUALS) begin
			queue_event(EV_KEY, SEC_QUERY, 8'h00, 1'b0);
		end else if (s == SEC_QUERY && b == CH_AMP) begin
			queue_event(EV_PAIR, SEC_QUERY, 8'h00, 1'b0);
		end else begin
			queue_event(EV_BYTE, s, b, 1'b0);
		end
		model_section = s;
		if (fin) begin
			if (s == SEC_QUERY) begin
				queue_event(EV_PAIR, SEC_QUERY, 8'h00, 1'b0);
			end
			queue_event(EV_END, s, 8'h00, 1'b1);
			model_section = SEC_PATH;
			model_escape = ESC_IDLE;
			model_nibble = 4'd0;
		end
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) begin
			return 0;
		end else if (r < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	task automatic send_word(input logic [7:0] b, input logic fin);
		int gap;
		gap = gap_on ? pick_gap() : 0;
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_byte <= b;
		is_final <= fin;
		do @(posedge clk); while (in_stall);
		predict_events(b, fin);
		items_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) begin
			send_word(s[i], i == s.len() - 1);
		end
	endtask

	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_events.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic build_random_url(output logic [7:0] url[$]);
		string alnum;
		string hexd;
		int target;
		int r;
		alnum = "0123456789abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ";
		hexd = "0123456789abcdefABCDEF";
		url = {};
		target = $urandom_range(1, 24);
		while (url.size() < target) begin
			r = $urandom_range(0, 99);
			if (r < 40) begin
				url = {url, alnum[$urandom_range(0, 61)]};
			end else if (r < 55) begin
				url = {url, CH_PERCENT};
				repeat (2) begin
					if ($urandom_range(0, 4) == 0) begin
						url = {url, 8'($urandom_range(0, 255))};
					end else begin
						url = {url, hexd[$urandom_range(0, 21)]};
					end
				end
			end else if (r < 63) begin
				url = {url, CH_QUESTION};
			end else if (r < 71) begin
				url = {url, CH_HASH};
			end else if (r < 79) begin
				url = {url, CH_EQUALS};
			end else if (r < 87) begin
				url = {url, CH_AMP};
			end else begin
				url = {url, 8'($urandom_range(0, 255))};
			end
		end
		// now and then cut the tail so an escape may end early
		if (url.size() > 2 && $urandom_range(0, 9) == 0) begin
			void'(url.pop_back());
		end
	endtask

	task automatic send_random_urls(input int count);
		logic [7:0] url[$];
		int stop_at;
		stop_at = items_sent + count;
		while (items_sent < stop_at) begin
			build_random_url(url);
			foreach (url[i]) begin
				send_word(url[i], i == url.size() - 1);
			end
		end
	endtask

	task automatic test_extreme_bytes();
		send_word(8'h00, 1'b0);
		send_word(8'hFF, 1'b1);
	endtask

	task automatic test_escapes();
		// good escape, bad high hex, escape cut on the last byte
		send_text("%4a%GF%");
	endtask

	task automatic test_query_marks();
		// marks inside an escape, '?' inside the query, query closed by '#',
		// '?' and '#' inside the fragment, escape cut after one hex byte
		send_text("?k=%&?&?#x#?%3");
	endtask

	task automatic test_empty_sections();
		send_text("?");
		send_text("#");
	endtask

	task automatic test_random_traffic(input int count);
		gap_on = 1'b1;
		stall_on = 1'b1;
		send_random_urls(count);
	endtask

	task automatic test_full_rate(input int count);
		gap_on = 1'b0;
		stall_on = 1'b0;
		send_random_urls(count);
		gap_on = 1'b1;
		stall_on = 1'b1;
	endtask

	task automatic test_pause_mid_url();
		logic [7:0] url[$];
		repeat (4) begin
			build_random_url(url);
			foreach (url[i]) begin
				if (i == url.size() / 2) begin
					wait_drained();
				end
				send_word(url[i], i == url.size() - 1);
			end
		end
	endtask

	// output side stall pattern
	always @(negedge clk) begin
		if (!stall_on) begin
			stall_left = 0;
			out_stall <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else begin
			stall_roll = $urandom_range(0, 99);
			if (stall_roll < 65) begin
				out_stall <= 1'b0;
			end else if (stall_roll < 95) begin
				stall_left = $urandom_range(0, 2);
				out_stall <= 1'b1;
			end else begin
				stall_left = $urandom_range(10, 30);
				out_stall <= 1'b1;
			end
		end
	end

	// result word checker
	always @(posedge clk) begin
		url_event_t got;
		url_event_t want;
		if (arst_n && out_valid && !out_stall) begin
			got = {event_res, section, out_byte, run_last};
			if (pending_events.size() == 0) begin
				$display("%0t: unexpected word ev=%0d sec=%0d byte=%02h last=%0d",
					$time, got.ev, got.sec, got.data, got.last);
				errors++;
			end else begin
				want = pending_events.pop_front();
				if (got !== want) begin
					$display("%0t: mismatch expected %0d/%0d/%02h/%0d, got %0d/%0d/%02h/%0d",
						$time, want.ev, want.sec, want.data, want.last,
						got.ev, got.sec, got.data, got.last);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("** url_component_decoder: FAILED **");
			$finish;
		end
	end

	initial begin
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		test_extreme_bytes();
		test_escapes();
		test_query_marks();
		test_empty_sections();
		test_random_traffic(150);
		test_full_rate(80);
		test_pause_mid_url();
		test_random_traffic(80);
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_events.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (errors == 0) begin
			$display("** url_component_decoder: PASSED **");
		end else begin
			$display("** url_component_decoder: FAILED **");
		end
		$finish;
	end

endmodule
